// ----- hdl/sact_pkg.sv -----
// ----------------------------------------------------------------------------
// sact_pkg
// shared types, constants and helpers of the cache tag store
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

    localparam int SET_COUNT = 256;
    localparam int MAX_ASSOC = 16;
    localparam int ADDR_BITS = 32;

    localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W  = (MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1;
    localparam int LINE_W = SET_W + WAY_W;
    localparam int LINES  = SET_COUNT * MAX_ASSOC;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_WAYS   = 2'd1;
    localparam logic [1:0] CFG_SIB    = 2'd2;

    localparam logic KIND_LOOKUP  = 1'b0;
    localparam logic KIND_INSTALL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] line_address;
        logic        set_dirty;
        logic [31:0] time_stamp;
    } word_in_t;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [31:0] evicted_tag;
        logic        evicted_dirty;
        logic [31:0] read_access_count;
        logic [31:0] write_access_count;
        logic [31:0] read_miss_count;
        logic [31:0] write_miss_count;
        logic [31:0] dirty_evict_count;
    } word_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_SCAN,
        ST_RAND,
        ST_RPICK,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic read_way;
        logic scan_way;
        logic rand_pick;
        logic rand_rem;
        logic finish;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic last_way;
        logic need_rand;
    } dp_stat_t;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic b;
        b = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {b, s[15:1]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sact_ctrl.sv -----
// ----------------------------------------------------------------------------
// sact_ctrl
// sequencer: clearing pass, way scan, random pick, finish
// ----------------------------------------------------------------------------
`default_nettype none

module sact_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire sact_pkg::dp_stat_t stat,
    output sact_pkg::dp_cmd_t       cmd,
    output logic                    busy
);
    import sact_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_READ;
            ST_CLEAR:  if (stat.clear_done) state_next = ST_IDLE;
            ST_READ:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (stat.last_way)
                    state_next = stat.need_rand ? ST_RAND : ST_FINISH;
            end
            ST_RAND:   state_next = ST_RPICK;
            ST_RPICK:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_READ:   cmd.read_way = 1'b1;
            ST_SCAN:
            begin
                cmd.scan_way = 1'b1;
                cmd.read_way = !stat.last_way;
            end
            ST_RAND:   cmd.rand_pick = 1'b1;
            ST_RPICK:  cmd.rand_rem = 1'b1;
            ST_FINISH: cmd.finish = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/sact_dp.sv -----
// ----------------------------------------------------------------------------
// sact_dp
// tag store memories, way scan, victim choice and counters
// ----------------------------------------------------------------------------
`default_nettype none

module sact_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sact_pkg::dp_cmd_t  cmd,
    input  wire sact_pkg::word_in_t in_word,
    input  wire logic               policy,
    input  wire logic [4:0]         ways_cfg,
    input  wire logic [3:0]         sib_cfg,
    output sact_pkg::dp_stat_t      stat,
    output sact_pkg::word_out_t     out_word,
    output logic                    done
);
    import sact_pkg::*;

    // memories: one entry per line
    logic        valid_mem [LINES];
    logic [31:0] tag_mem   [LINES];
    logic        dirty_mem [LINES];
    logic [31:0] stamp_mem [LINES];

    logic        rd_valid_reg, rd_dirty_reg;
    logic [31:0] rd_tag_reg, rd_stamp_reg;

    logic [LINE_W-1:0] clr_reg;
    logic              clr_done_reg;

    // latched item
    logic              kind_reg, mdirty_reg;
    logic [31:0]       tag_reg, stamp_reg;
    logic [SET_W-1:0]  set_reg;
    logic [5:0]        ways_reg;

    // scan state
    logic [WAY_W:0]    rd_way_reg;  // address way being read
    logic [WAY_W:0]    sc_way_reg;  // way whose data is in rd_*_reg
    logic              found_reg;   // hit way or invalid way found
    logic [WAY_W-1:0]  pick_reg;
    logic [31:0]       best_reg;
    logic [WAY_W-1:0]  lru_reg;
    logic [31:0]       lru_tag_reg;
    logic              lru_dirty_reg;
    logic [31:0]       pick_tag_reg;
    logic              pick_dirty_reg;
    logic [15:0]       lfsr_reg;
    logic [15:0]       quot_reg;

    logic [31:0] rd_cnt_reg, wr_cnt_reg, rm_cnt_reg, wm_cnt_reg, de_cnt_reg;
    word_out_t   out_reg;
    logic        done_reg;

    logic [63:0]       addr_w;
    logic [31:0]       tag_w;
    logic [63:0]       set_w;
    logic [5:0]        ways_w;
    logic [LINE_W-1:0] rd_addr, wr_addr;
    logic [WAY_W-1:0]  sc_way;
    logic              match_w, take_w, last_w;
    logic [WAY_W-1:0]  rand_way;
    logic [15:0]       lfsr_new;
    logic [21:0]       recip_w;
    logic [37:0]       prod_w;
    logic [21:0]       qd_w;
    logic [15:0]       rem_w;
    logic [WAY_W-1:0]  vic_way;
    logic              wr_en;

    // address split
    always_comb
    begin
        addr_w = {32'd0, in_word.line_address};
        if (ADDR_BITS < 64)
            addr_w = addr_w & ((64'd1 << ADDR_BITS) - 64'd1);
        tag_w  = 32'(addr_w >> sib_cfg);
        set_w  = addr_w & ((64'd1 << sib_cfg) - 64'd1);
        ways_w = (ways_cfg == 5'd0) ? 6'd1 :
                 ({1'b0, ways_cfg} > 6'(MAX_ASSOC)) ? 6'(MAX_ASSOC) : {1'b0, ways_cfg};
    end

    assign sc_way  = sc_way_reg[WAY_W-1:0];
    assign rd_addr = cmd.clear_step ? clr_reg : {set_reg, rd_way_reg[WAY_W-1:0]};
    assign last_w  = ({1'b0, sc_way_reg} + 7'd1) >= {1'b0, ways_reg};

    // lookup: valid and tag equal; install: invalid way
    assign match_w = (kind_reg == KIND_LOOKUP) ? (rd_valid_reg && rd_tag_reg == tag_reg)
                                               : !rd_valid_reg;
    assign take_w  = cmd.scan_way && !found_reg && match_w;

    // ceil(2^21 / ways): exact quotient for any 16-bit value
    always_comb
    begin
        case (ways_reg)
            6'd1:    recip_w = 22'd2097152;
            6'd2:    recip_w = 22'd1048576;
            6'd3:    recip_w = 22'd699051;
            6'd4:    recip_w = 22'd524288;
            6'd5:    recip_w = 22'd419431;
            6'd6:    recip_w = 22'd349526;
            6'd7:    recip_w = 22'd299594;
            6'd8:    recip_w = 22'd262144;
            6'd9:    recip_w = 22'd233017;
            6'd10:   recip_w = 22'd209716;
            6'd11:   recip_w = 22'd190651;
            6'd12:   recip_w = 22'd174763;
            6'd13:   recip_w = 22'd161320;
            6'd14:   recip_w = 22'd149797;
            6'd15:   recip_w = 22'd139811;
            6'd16:   recip_w = 22'd131072;
            default: recip_w = 22'd2097152;
        endcase
    end

    // random victim: quotient registered in ST_RAND, remainder taken from it in ST_RPICK
    assign lfsr_new = lfsr_next(lfsr_reg);
    assign prod_w   = 38'(lfsr_new) * 38'(recip_w);
    assign qd_w     = 22'(quot_reg) * 22'(ways_reg);
    assign rem_w    = 16'(22'(lfsr_reg) - qd_w);
    assign rand_way = rem_w[WAY_W-1:0];

    assign vic_way = found_reg ? pick_reg : (policy ? pick_reg : lru_reg);
    assign wr_en   = cmd.finish && (kind_reg == KIND_INSTALL || found_reg);
    assign wr_addr = {set_reg, vic_way};

    always_ff @(posedge clk)
    begin
        if (cmd.read_way || cmd.clear_step)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_dirty_reg <= dirty_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
        if (cmd.clear_step)
            valid_mem[clr_reg] <= 1'b0;
        else if (wr_en)
        begin
            valid_mem[wr_addr] <= 1'b1;
            stamp_mem[wr_addr] <= stamp_reg;
            if (kind_reg == KIND_INSTALL)
            begin
                tag_mem[wr_addr]   <= tag_reg;
                dirty_mem[wr_addr] <= mdirty_reg;
            end
            else if (mdirty_reg)
                dirty_mem[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            found_reg    <= 1'b0;
            lfsr_reg     <= LFSR_SEED;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
            rm_cnt_reg   <= '0;
            wm_cnt_reg   <= '0;
            de_cnt_reg   <= '0;
            done_reg     <= 1'b0;
            rd_way_reg   <= '0;
            sc_way_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.clear_step)
            begin
                clr_reg      <= clr_reg + 1'b1;
                clr_done_reg <= (clr_reg == LINE_W'(LINES - 1));
            end
            if (cmd.load)
            begin
                kind_reg   <= in_word.kind;
                mdirty_reg <= in_word.set_dirty;
                stamp_reg  <= in_word.time_stamp;
                tag_reg    <= tag_w;
                set_reg    <= SET_W'(set_w % 64'(SET_COUNT));
                ways_reg   <= ways_w;
                rd_way_reg <= '0;
                sc_way_reg <= '0;
                found_reg  <= 1'b0;
                if (in_word.kind == KIND_LOOKUP)
                begin
                    if (in_word.set_dirty) wr_cnt_reg <= wr_cnt_reg + 1'b1;
                    else                   rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
            end
            if (cmd.read_way)
                rd_way_reg <= rd_way_reg + 1'b1;
            if (cmd.scan_way)
            begin
                sc_way_reg <= sc_way_reg + 1'b1;
                if (take_w)
                begin
                    found_reg <= 1'b1;
                    pick_reg  <= sc_way;
                end
                if (sc_way_reg == '0 || rd_stamp_reg < best_reg)
                begin
                    best_reg      <= rd_stamp_reg;
                    lru_reg       <= sc_way;
                    lru_tag_reg   <= rd_tag_reg;
                    lru_dirty_reg <= rd_dirty_reg;
                end
            end
            if (cmd.rand_pick)
            begin
                lfsr_reg <= lfsr_new;
                quot_reg <= prod_w[36:21];
            end
            if (cmd.rand_rem)
                pick_reg <= rand_way;
            if (cmd.finish)
            begin
                done_reg <= 1'b1;
                out_reg.hit           <= (kind_reg == KIND_LOOKUP) && found_reg;
                out_reg.evicted       <= 1'b0;
                out_reg.evicted_tag   <= '0;
                out_reg.evicted_dirty <= 1'b0;
                if (kind_reg == KIND_LOOKUP && !found_reg)
                begin
                    if (mdirty_reg) wm_cnt_reg <= wm_cnt_reg + 1'b1;
                    else            rm_cnt_reg <= rm_cnt_reg + 1'b1;
                end
                if (kind_reg == KIND_INSTALL && !found_reg)
                begin
                    out_reg.evicted       <= 1'b1;
                    out_reg.evicted_tag   <= policy ? pick_tag_reg : lru_tag_reg;
                    out_reg.evicted_dirty <= policy ? pick_dirty_reg : lru_dirty_reg;
                    if (policy ? pick_dirty_reg : lru_dirty_reg)
                        de_cnt_reg <= de_cnt_reg + 1'b1;
                end
            end
        end
    end

    // random victim data: second read of the chosen way
    always_ff @(posedge clk)
    begin
        if (cmd.rand_rem)
        begin
            pick_tag_reg   <= tag_mem[{set_reg, rand_way}];
            pick_dirty_reg <= dirty_mem[{set_reg, rand_way}];
        end
    end

    assign stat.clear_done = clr_done_reg;
    assign stat.last_way   = last_w;
    assign stat.need_rand  = (kind_reg == KIND_INSTALL) && !found_reg && !take_w && policy;

    always_comb
    begin
        out_word.hit                = out_reg.hit;
        out_word.evicted            = out_reg.evicted;
        out_word.evicted_tag        = out_reg.evicted_tag;
        out_word.evicted_dirty      = out_reg.evicted_dirty;
        out_word.read_access_count  = rd_cnt_reg;
        out_word.write_access_count = wr_cnt_reg;
        out_word.read_miss_count    = rm_cnt_reg;
        out_word.write_miss_count   = wm_cnt_reg;
        out_word.dirty_evict_count  = de_cnt_reg;
    end
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hdl/set_assoc_cache_tag_store_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store_core
// tag store of a set-associative cache with lru or pseudo-random replacement
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start & !busy           in_word (kind, address, dirty, stamp)
//  output    done strobe, 1 cycle    out_word (hit, eviction, counters)
//  config    cfg_we                  cfg_index, cfg_data
//
//  an item takes one tag-store read per way over a
//  single memory port, plus, when a random victim is picked, an lfsr step
//  with reciprocal multiply, then the remainder and victim read
//  after reset a clearing pass sweeps the valid bits; busy stays high
//  meanwhile, config writes are taken as always
//  the receiver cannot stall: each result is shown for one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_store_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire sact_pkg::word_in_t  in_word,
    output logic                     done,
    output sact_pkg::word_out_t      out_word,
    input  wire logic                cfg_we,
    input  wire logic [4:0]          cfg_index,
    input  wire logic [4:0]          cfg_data
);
    import sact_pkg::*;

    logic       policy_reg;
    logic [4:0] ways_reg;
    logic [3:0] sib_reg;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            ways_reg   <= 5'd16;
            sib_reg    <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                5'(CFG_POLICY): policy_reg <= cfg_data[0];
                5'(CFG_WAYS):   ways_reg   <= cfg_data;
                5'(CFG_SIB):    sib_reg    <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    sact_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sact_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (in_word),
        .policy   (policy_reg),
        .ways_cfg (ways_reg),
        .sib_cfg  (sib_reg),
        .stat     (stat),
        .out_word (out_word),
        .done     (done)
    );

endmodule

`default_nettype wire

// ----- tb/set_assoc_cache_tag_store_core_test.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store_core_test
// self-checking bench: lookups and installs against a behavioral tag store
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_store_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sact_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 40;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    word_in_t  in_word;
    logic      done;
    word_out_t out_word;
    logic      cfg_we;
    logic [4:0] cfg_index;
    logic [4:0] cfg_data;

    set_assoc_cache_tag_store_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .done      (done),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // behavioral copy of the tag store
    logic        shadow_valid [LINES];
    logic [31:0] shadow_tag   [LINES];
    logic        shadow_dirty [LINES];
    logic [31:0] shadow_stamp [LINES];
    logic [31:0] cnt_rd, cnt_wr, cnt_rd_miss, cnt_wr_miss, cnt_dirty_ev;
    logic [15:0] shadow_lfsr;
    logic        pol_reg;
    logic [4:0]  ways_reg;
    logic [3:0]  sib_reg;

    word_in_t  pending_words [$];
    word_out_t expected_words[$];

    int  send_idle_pct;
    int  quiet_cycles;
    int  errors;
    int  words_sent;
    int  words_checked;
    int  evictions_seen;
    int  hits_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // computes the result of one word and updates the shadow store
    function automatic word_out_t tag_store_access(input word_in_t w);
        word_out_t   r;
        int          ways;
        int          set_idx;
        int          base;
        int          victim;
        logic [31:0] tag;
        logic [31:0] best;
        r = '0;
        ways = (ways_reg == 0) ? 1 : ((ways_reg > MAX_ASSOC) ? MAX_ASSOC : ways_reg);
        set_idx = int'((w.line_address & ((33'd1 << sib_reg) - 1))) % SET_COUNT;
        tag = w.line_address >> sib_reg;
        base = set_idx * MAX_ASSOC;
        if (w.kind == KIND_LOOKUP)
        begin
            if (w.set_dirty) cnt_wr++; else cnt_rd++;
            for (int i = 0; i < ways; i++)
            begin
                if (shadow_valid[base + i] && shadow_tag[base + i] == tag)
                begin
                    r.hit = 1'b1;
                    shadow_stamp[base + i] = w.time_stamp;
                    if (w.set_dirty) shadow_dirty[base + i] = 1'b1;
                    break;
                end
            end
            if (!r.hit)
            begin
                if (w.set_dirty) cnt_wr_miss++; else cnt_rd_miss++;
            end
        end
        else
        begin
            victim = ways;
            for (int i = 0; i < ways; i++)
            begin
                if (!shadow_valid[base + i])
                begin
                    victim = i;
                    break;
                end
            end
            if (victim == ways)
            begin
                if (pol_reg == 1'b0)
                begin
                    // oldest stamp wins, lowest way on ties
                    best = shadow_stamp[base];
                    victim = 0;
                    for (int i = 1; i < ways; i++)
                    begin
                        if (shadow_stamp[base + i] < best)
                        begin
                            best = shadow_stamp[base + i];
                            victim = i;
                        end
                    end
                end
                else
                begin
                    shadow_lfsr = {shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3]
                                   ^ shadow_lfsr[5], shadow_lfsr[15:1]};
                    victim = int'(shadow_lfsr) % ways;
                end
                r.evicted = 1'b1;
                r.evicted_tag = shadow_tag[base + victim];
                r.evicted_dirty = shadow_dirty[base + victim];
                if (r.evicted_dirty) cnt_dirty_ev++;
            end
            shadow_valid[base + victim] = 1'b1;
            shadow_tag[base + victim]   = tag;
            shadow_dirty[base + victim] = w.set_dirty;
            shadow_stamp[base + victim] = w.time_stamp;
        end
        r.read_access_count  = cnt_rd;
        r.write_access_count = cnt_wr;
        r.read_miss_count    = cnt_rd_miss;
        r.write_miss_count   = cnt_wr_miss;
        r.dirty_evict_count  = cnt_dirty_ev;
        return r;
    endfunction

    // driver: one word from the pending queue per accepted handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            in_word <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_words.push_back(tag_store_access(in_word));
                words_sent++;
            end
            if (!(start && busy))
            begin
                // idle on random cycles, never while a word waits on busy
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    start   <= 1'b1;
                    in_word <= pending_words.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every done strobe is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                word_out_t e;
                e = expected_words.pop_front();
                words_checked++;
                if (e.hit) hits_seen++;
                if (e.evicted) evictions_seen++;
                if (out_word.hit !== e.hit)
                begin
                    $error("hit exp %0h got %0h", e.hit, out_word.hit);
                    errors++;
                end
                if (out_word.evicted !== e.evicted)
                begin
                    $error("evicted exp %0h got %0h", e.evicted, out_word.evicted);
                    errors++;
                end
                if (out_word.evicted_tag !== e.evicted_tag)
                begin
                    $error("evicted_tag exp %0h got %0h", e.evicted_tag, out_word.evicted_tag);
                    errors++;
                end
                if (out_word.evicted_dirty !== e.evicted_dirty)
                begin
                    $error("evicted_dirty exp %0h got %0h", e.evicted_dirty,
                           out_word.evicted_dirty);
                    errors++;
                end
                if (out_word.read_access_count !== e.read_access_count)
                begin
                    $error("read_access_count exp %0h got %0h", e.read_access_count,
                           out_word.read_access_count);
                    errors++;
                end
                if (out_word.write_access_count !== e.write_access_count)
                begin
                    $error("write_access_count exp %0h got %0h", e.write_access_count,
                           out_word.write_access_count);
                    errors++;
                end
                if (out_word.read_miss_count !== e.read_miss_count)
                begin
                    $error("read_miss_count exp %0h got %0h", e.read_miss_count,
                           out_word.read_miss_count);
                    errors++;
                end
                if (out_word.write_miss_count !== e.write_miss_count)
                begin
                    $error("write_miss_count exp %0h got %0h", e.write_miss_count,
                           out_word.write_miss_count);
                    errors++;
                end
                if (out_word.dirty_evict_count !== e.dirty_evict_count)
                begin
                    $error("dirty_evict_count exp %0h got %0h", e.dirty_evict_count,
                           out_word.dirty_evict_count);
                    errors++;
                end
            end
        end
    end

    // watchdog: counts cycles with no accepted word in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog expired, %0d words still expected", expected_words.size());
            $display("[set_assoc_cache_tag_store_core] ERROR");
            $finish;
        end
    end

    // waits until the driver has consumed everything and all results are back
    task automatic drain_all();
        while (pending_words.size() > 0 || start || expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write at a clock edge; shadow copy follows the same masking
    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= 5'(idx);
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_POLICY: pol_reg  = val[0];
            CFG_WAYS:   ways_reg = val;
            CFG_SIB:    sib_reg  = val[3:0];
            default: ;
        endcase
    endtask

    function automatic word_in_t make_word(input logic k, input logic [31:0] a,
                                           input logic d, input logic [31:0] s);
        word_in_t w;
        w.kind = k;
        w.line_address = a;
        w.set_dirty = d;
        w.time_stamp = s;
        return w;
    endfunction

    // random phase: install/lookup mix over a small address pool so hits,
    // full sets and evictions are frequent, plus some fully random noise
    task automatic random_phase(input int n, input int idle_pct);
        logic [31:0] pool [16];
        logic [31:0] a;
        int          set_mask;
        send_idle_pct = idle_pct;
        set_mask = (sib_reg >= 2) ? 3 : 0;
        foreach (pool[i])
            pool[i] = ($urandom() << sib_reg) | ($urandom_range(3) & set_mask);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                a = $urandom();
            else
                a = pool[$urandom_range(15)];
            pending_words.push_back(make_word(1'($urandom_range(1)), a,
                                              1'($urandom_range(1)), $urandom()));
        end
        drain_all();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        hits_seen = 0;
        evictions_seen = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        cnt_rd = '0; cnt_wr = '0; cnt_rd_miss = '0; cnt_wr_miss = '0; cnt_dirty_ev = '0;
        shadow_lfsr = LFSR_SEED;
        pol_reg = 1'b0;
        ways_reg = 5'd16;
        sib_reg = 4'd8;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one set of two ways, lru first
        write_reg(CFG_WAYS, 5'd2);
        write_reg(CFG_SIB, 5'd8);
        write_reg(CFG_POLICY, 5'd0);
        pending_words.push_back(make_word(KIND_LOOKUP, 32'h0000_0005, 1'b0, 32'd10));
        pending_words.push_back(make_word(KIND_INSTALL, 32'h0000_0005, 1'b1, 32'd0));
        pending_words.push_back(make_word(KIND_INSTALL, 32'hFFFF_FF05, 1'b0, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(KIND_LOOKUP, 32'h0000_0005, 1'b1, 32'd20));
        pending_words.push_back(make_word(KIND_LOOKUP, 32'hFFFF_FF05, 1'b0, 32'd20));
        // equal stamps: lowest way is the victim
        pending_words.push_back(make_word(KIND_INSTALL, 32'h1234_5605, 1'b0, 32'd7));
        pending_words.push_back(make_word(KIND_INSTALL, 32'h0000_0005, 1'b0, 32'd7));
        // same tag installed twice
        pending_words.push_back(make_word(KIND_INSTALL, 32'h0000_0005, 1'b1, 32'd8));
        pending_words.push_back(make_word(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'd9));
        pending_words.push_back(make_word(KIND_LOOKUP, 32'h0000_0000, 1'b0, 32'd9));
        drain_all();   // sender holds off until every result is back

        // directed: random victim, ways 0 acts as 1, set bits beyond the sets
        write_reg(CFG_POLICY, 5'd1);
        write_reg(CFG_WAYS, 5'd0);
        write_reg(CFG_SIB, 5'd15);
        for (int i = 0; i < 4; i++)
            pending_words.push_back(make_word(KIND_INSTALL, 32'h0001_0003 + (i << 15),
                                              i[0], 32'd100 + i));
        drain_all();
        write_reg(CFG_WAYS, 5'd31);
        pending_words.push_back(make_word(KIND_LOOKUP, 32'h8001_0003, 1'b1, 32'd5));
        drain_all();
        write_reg(CFG_WAYS, 5'd3);
        for (int i = 0; i < 6; i++)
            pending_words.push_back(make_word(KIND_INSTALL, 32'h0000_0103 + (i << 15),
                                              1'b1, 32'd1));
        drain_all();

        // random phases over several settings, extremes included
        write_reg(CFG_POLICY, 5'd0); write_reg(CFG_WAYS, 5'd4); write_reg(CFG_SIB, 5'd2);
        random_phase(300, 6);
        write_reg(CFG_POLICY, 5'd1); write_reg(CFG_WAYS, 5'd16); write_reg(CFG_SIB, 5'd0);
        random_phase(300, 83);
        write_reg(CFG_POLICY, 5'd0); write_reg(CFG_WAYS, 5'd1); write_reg(CFG_SIB, 5'd8);
        random_phase(300, 0);
        write_reg(CFG_POLICY, 5'd1); write_reg(CFG_WAYS, 5'd3); write_reg(CFG_SIB, 5'd4);
        random_phase(300, 6);
        write_reg(CFG_POLICY, 5'd0); write_reg(CFG_WAYS, 5'd16); write_reg(CFG_SIB, 5'd1);
        random_phase(300, 83);
        write_reg(CFG_POLICY, 5'd1); write_reg(CFG_WAYS, 5'd2); write_reg(CFG_SIB, 5'd8);
        random_phase(300, 0);

        $display("%0d words sent, %0d results checked, %0d hits, %0d evictions",
                 words_sent, words_checked, hits_seen, evictions_seen);
        $display("covered lru and random victims, 1..16 ways, 0..15 set index bits");
        if (errors == 0 && expected_words.size() == 0)
            $display("[set_assoc_cache_tag_store_core] OK");
        else
            $display("[set_assoc_cache_tag_store_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/sact_pkg.sv
hdl/sact_ctrl.sv
hdl/sact_dp.sv
hdl/set_assoc_cache_tag_store_core.sv
tb/set_assoc_cache_tag_store_core_test.sv
